FILE: sv/bpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_pkg
// Shared constants for the bicubic pixel interpolator: sample geometry,
// default fraction width, pipeline depth of one cubic lane and clamp limit.
// ----------------------------------------------------------------------------
package bpi_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int SAMPLE_W      = 8;
    localparam int NUM_TAPS      = 4;
    localparam int ROW_W         = SAMPLE_W * NUM_TAPS;
    // Integer bits, sign included, of a row result with its overshoot.
    localparam int ROW_HEAD      = 11;
    // Headroom bits the cubic needs over its input width.
    localparam int CUBIC_HEAD    = 5;
    localparam int CUBIC_LAT     = 5;
    localparam int PIX_MAX       = 255;

endpackage : bpi_pkg
`default_nettype wire

FILE: sv/bicubic_pixel_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bicubic_pixel_interpolator
// Catmull-Rom bicubic interpolation of one 8-bit sample from a 4x4
// neighborhood: four row lanes run the horizontal cubic side by side and a
// merging stage runs the vertical cubic and the clamp.
//
//   Channel   Handshake            Payload
//   input     i_valid / o_stall    i_row_0..i_row_3, i_frac_x, i_frac_y
//   output    o_valid / i_stall    o_pixel_out
//
// One word is accepted every cycle unless a stalled result holds the
// pipeline. The pipeline is two five-stage cubic pipelines, each
// with three chained multiplies, plus the clamp register.
// Reset clears only the valid pipeline; data registers are not reset.
// A stalled result freezes the whole pipeline, and o_stall follows it.
// ----------------------------------------------------------------------------
module bicubic_pixel_interpolator #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bpi_pkg::ROW_W-1:0]     i_row_0,
    input  logic [bpi_pkg::ROW_W-1:0]     i_row_1,
    input  logic [bpi_pkg::ROW_W-1:0]     i_row_2,
    input  logic [bpi_pkg::ROW_W-1:0]     i_row_3,
    input  logic [bpi_pkg::SAMPLE_W-1:0]  i_frac_x,
    input  logic [bpi_pkg::SAMPLE_W-1:0]  i_frac_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bpi_pkg::SAMPLE_W-1:0]  o_pixel_out
);
    import bpi_pkg::*;

    localparam int PW  = FRAC_BITS + SAMPLE_W + 1;
    localparam int CW  = FRAC_BITS + ROW_HEAD;
    localparam int LAT = 2 * CUBIC_LAT + 1;

    logic                  w_en;
    logic [ROW_W-1:0]      w_row [NUM_TAPS];
    logic [FRAC_BITS-1:0]  w_fx, w_fy;
    logic signed [PW-1:0]  w_p [NUM_TAPS][NUM_TAPS];
    logic signed [CW-1:0]  w_col [NUM_TAPS];

    logic [LAT-1:0]        r_vld;
    logic [FRAC_BITS-1:0]  r_fy [CUBIC_LAT];

    assign w_row[0] = i_row_0;
    assign w_row[1] = i_row_1;
    assign w_row[2] = i_row_2;
    assign w_row[3] = i_row_3;
    assign w_fx     = FRAC_BITS'(i_frac_x);
    assign w_fy     = FRAC_BITS'(i_frac_y);

    assign o_valid = r_vld[LAT-1];
    assign o_stall = r_vld[LAT-1] & i_stall;
    assign w_en    = ~o_stall;

    for (genvar r = 0; r < NUM_TAPS; r++) begin : g_lane
        for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
            assign w_p[r][k] = {1'b0, w_row[r][SAMPLE_W*k +: SAMPLE_W], {FRAC_BITS{1'b0}}};
        end

        bpi_cubic #(
            .FRAC_BITS (FRAC_BITS),
            .PW        (PW),
            .OW        (CW)
        ) u_row (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_p   (w_p[r]),
            .i_f   (w_fx),
            .o_y   (w_col[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fy[0] <= w_fy;
            for (int s = 1; s < CUBIC_LAT; s++) begin
                r_fy[s] <= r_fy[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    bpi_merge #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_col   (w_col),
        .i_f     (r_fy[CUBIC_LAT-1]),
        .o_pixel (o_pixel_out)
    );

`ifndef NO_ASSERTIONS
    a_stall_needs_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("o_stall raised without a pending output word");

    a_reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_pipe_advances : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_vld[LAT-2] |=> o_valid)
        else $error("word lost in the last pipeline stage");
`endif

endmodule : bicubic_pixel_interpolator
`default_nettype wire

FILE: sv/bpi_cubic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_cubic
// Five-stage Catmull-Rom cubic in Horner form on four signed fixed-point taps,
// with floor after every product. The first and last stages hold no multiplier; each other stage holds one.
// ----------------------------------------------------------------------------
module bpi_cubic #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF,
    parameter int PW        = FRAC_BITS + 9,
    parameter int OW        = FRAC_BITS + 11
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [PW-1:0] i_p [bpi_pkg::NUM_TAPS],
    input  logic [FRAC_BITS-1:0] i_f,
    output logic signed [OW-1:0] o_y
);
    import bpi_pkg::*;

    localparam int IW = PW + CUBIC_HEAD;
    localparam int MW = IW + FRAC_BITS + 1;

    logic signed [IW-1:0] w_e0, w_e1, w_e2, w_e3, w_d12;
    logic signed [IW-1:0] n_a, n_b, n_c;
    logic signed [IW-1:0] w_h1, w_h2, w_h3;

    logic signed [IW-1:0] r_a, r_b1, r_b2, r_c1, r_c2, r_c3;
    logic signed [PW-1:0] r_p1_1, r_p1_2, r_p1_3, r_p1_4;
    logic [FRAC_BITS-1:0] r_f1, r_f2, r_f3;
    logic signed [MW-1:0] r_m1, r_m2, r_m3;
    logic signed [OW-1:0] r_y;

    always_comb begin
        w_e0  = IW'(i_p[0]);
        w_e1  = IW'(i_p[1]);
        w_e2  = IW'(i_p[2]);
        w_e3  = IW'(i_p[3]);
        w_d12 = w_e1 - w_e2;
        n_a   = (w_d12 <<< 1) + w_d12 + w_e3 - w_e0;
        n_b   = (w_e0 <<< 1) - (w_e1 <<< 2) - w_e1 + (w_e2 <<< 2) - w_e3;
        n_c   = w_e2 - w_e0;
        w_h1  = IW'(r_m1 >>> FRAC_BITS) + r_b2;
        w_h2  = IW'(r_m2 >>> FRAC_BITS) + r_c3;
        w_h3  = IW'(r_m3 >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b1   <= n_b;
            r_c1   <= n_c;
            r_p1_1 <= i_p[1];
            r_f1   <= i_f;

            r_m1   <= r_a * $signed({1'b0, r_f1});
            r_b2   <= r_b1;
            r_c2   <= r_c1;
            r_p1_2 <= r_p1_1;
            r_f2   <= r_f1;

            r_m2   <= w_h1 * $signed({1'b0, r_f2});
            r_c3   <= r_c2;
            r_p1_3 <= r_p1_2;
            r_f3   <= r_f2;

            r_m3   <= w_h2 * $signed({1'b0, r_f3});
            r_p1_4 <= r_p1_3;

            r_y    <= OW'(IW'(r_p1_4) + (w_h3 >>> 1));
        end
    end

    assign o_y = r_y;

endmodule : bpi_cubic
`default_nettype wire

FILE: sv/bpi_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_merge
// Merging stage: vertical cubic over the four row results, then the drop of
// the fraction and the clamp to the sample range in an output register.
// ----------------------------------------------------------------------------
module bpi_merge #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF,
    parameter int CW        = FRAC_BITS + bpi_pkg::ROW_HEAD
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [CW-1:0]          i_col [bpi_pkg::NUM_TAPS],
    input  logic [FRAC_BITS-1:0]          i_f,
    output logic [bpi_pkg::SAMPLE_W-1:0]  o_pixel
);
    import bpi_pkg::*;

    localparam int VW = CW - FRAC_BITS;
    localparam logic signed [VW-1:0] PixMax = VW'(PIX_MAX);

    logic signed [CW-1:0]       w_y;
    logic signed [VW-1:0]       w_v;
    logic [SAMPLE_W-1:0]        n_pix;
    logic [SAMPLE_W-1:0]        r_pix;

    bpi_cubic #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (CW),
        .OW        (CW)
    ) u_col (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_p   (i_col),
        .i_f   (i_f),
        .o_y   (w_y)
    );

    always_comb begin
        w_v = VW'(w_y >>> FRAC_BITS);
        if (w_v < 0) begin
            n_pix = '0;
        end else if (w_v > PixMax) begin
            n_pix = SAMPLE_W'(PIX_MAX);
        end else begin
            n_pix = SAMPLE_W'(w_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_pixel = r_pix;

endmodule : bpi_merge
`default_nettype wire
